// ===== hw/rtl/msn_pkg.sv =====
// shared types and constants for the mask synapse spiking neuron core
`timescale 1ns / 1ps

package msn_pkg;

   // number of mask synapses and derived select width
   localparam int NUM_SYNAPSES = 8;
   localparam int SYN_SEL_W    = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;

   // field widths fixed by the interface
   localparam int DATA_W    = 8;
   localparam int SYN_IDX_W = 3;
   localparam int CSR_IDX_W = 8;

   // reset values
   localparam logic [DATA_W-1:0] MASK_RESET    = 8'hFF;
   localparam logic [DATA_W-1:0] DEFAULT_LEVEL = 8'((1 << 4) - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRE_THRESHOLD   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY_DELAY = 8'd1;

   // item kinds
   typedef enum logic [0:0] {
      OP_EVENT = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   // one input item
   typedef struct packed {
      opcode_type            opcode;
      logic [SYN_IDX_W-1:0]  synapse_index;
      logic [DATA_W-1:0]     input_value;
   } item_type;

   // one result item
   typedef struct packed {
      logic              fired;
      logic [DATA_W-1:0] spike_value;
   } result_type;

endpackage

// ===== hw/rtl/msn_input_stage.sv =====
// input register stage: captures one request transfer and holds it until it moves on
`timescale 1ns / 1ps

module msn_input_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [0:0]                       req_opcode,
   input  logic [msn_pkg::SYN_IDX_W-1:0]    req_synapse_index,
   input  logic [msn_pkg::DATA_W-1:0]       req_input_value,
   input  logic                             advance,
   output logic                             item_valid,
   output msn_pkg::item_type                item
);

   logic              valid_ff;
   logic              valid_in;
   msn_pkg::item_type item_ff;
   msn_pkg::item_type item_in;
   logic              take;

   // stall while a held item cannot move on
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // next valid and payload
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in              = 1'b1;
         item_in.opcode        = msn_pkg::opcode_type'(req_opcode);
         item_in.synapse_index = req_synapse_index;
         item_in.input_value   = req_input_value;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/msn_neuron_core.sv =====
// neuron state, configuration registers and the per-item update
`timescale 1ns / 1ps

module msn_neuron_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_go,
   input  msn_pkg::item_type                item,
   input  logic                             csr_valid,
   input  logic [msn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msn_pkg::DATA_W-1:0]       csr_data,
   output logic                             result_load,
   output msn_pkg::result_type              result
);

   logic [msn_pkg::DATA_W-1:0] mask_ff [msn_pkg::NUM_SYNAPSES];
   logic [msn_pkg::DATA_W-1:0] mask_in [msn_pkg::NUM_SYNAPSES];
   logic [msn_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic [msn_pkg::DATA_W-1:0] out_mask_ff, out_mask_in;
   logic [msn_pkg::DATA_W-1:0] timer_ff, timer_in;
   logic [msn_pkg::DATA_W-1:0] threshold_ff, threshold_in;
   logic [msn_pkg::DATA_W-1:0] delay_ff, delay_in;

   logic                           is_tick;
   logic                           idx_ok;
   logic [6:0]                     idx_wide;
   logic [msn_pkg::SYN_SEL_W-1:0]  sel;
   logic [msn_pkg::DATA_W-1:0]     sel_mask;
   logic [msn_pkg::DATA_W:0]       sum;
   logic [msn_pkg::DATA_W-1:0]     sat_sum;
   logic [msn_pkg::DATA_W-1:0]     timer_dec;
   logic [msn_pkg::DATA_W-1:0]     out_mask_shift;
   logic                           fire;

   // decode the item
   assign is_tick  = (item.opcode == msn_pkg::OP_TICK);
   assign idx_wide = 7'(item.synapse_index);
   assign sel      = idx_wide[msn_pkg::SYN_SEL_W-1:0];
   assign idx_ok   = (32'(item.synapse_index) < msn_pkg::NUM_SYNAPSES);
   assign sel_mask = mask_ff[sel];

   // saturating add of the masked input
   assign sum     = {1'b0, acc_ff} + {1'b0, item.input_value & sel_mask};
   assign sat_sum = sum[msn_pkg::DATA_W] ? msn_pkg::MASK_RESET : sum[msn_pkg::DATA_W-1:0];

   // tick side: timer countdown, output mask shift and fire decision
   assign timer_dec      = (timer_ff != '0) ? timer_ff - 8'd1 : timer_ff;
   assign out_mask_shift = {out_mask_ff[msn_pkg::DATA_W-2:0], 1'b1};
   assign fire           = (acc_ff > threshold_ff) && (timer_dec == '0);

   // next state
   always_comb begin
      acc_in      = acc_ff;
      out_mask_in = out_mask_ff;
      timer_in    = timer_ff;
      for (int i = 0; i < msn_pkg::NUM_SYNAPSES; i++) begin
         mask_in[i] = mask_ff[i];
      end
      if (item_go) begin
         if (is_tick) begin
            for (int i = 0; i < msn_pkg::NUM_SYNAPSES; i++) begin
               mask_in[i] = mask_ff[i] >> 1;
            end
            if (fire) begin
               acc_in      = '0;
               out_mask_in = '0;
               timer_in    = delay_ff;
            end else begin
               out_mask_in = out_mask_shift;
               timer_in    = timer_dec;
            end
         end else if (idx_ok) begin
            acc_in       = sat_sum;
            mask_in[sel] = {sel_mask[msn_pkg::DATA_W-2:0], 1'b1};
         end
      end
   end

   // configuration writes, unknown indexes dropped
   always_comb begin
      threshold_in = threshold_ff;
      delay_in     = delay_ff;
      if (csr_valid) begin
         case (csr_index)
            msn_pkg::CSR_FIRE_THRESHOLD:   threshold_in = csr_data;
            msn_pkg::CSR_REFRACTORY_DELAY: delay_in     = csr_data;
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msn_pkg::NUM_SYNAPSES; i++) begin
            mask_ff[i] <= msn_pkg::MASK_RESET;
         end
         acc_ff       <= '0;
         out_mask_ff  <= '0;
         timer_ff     <= '0;
         threshold_ff <= msn_pkg::DEFAULT_LEVEL;
         delay_ff     <= msn_pkg::DEFAULT_LEVEL;
      end else begin
         for (int i = 0; i < msn_pkg::NUM_SYNAPSES; i++) begin
            mask_ff[i] <= mask_in[i];
         end
         acc_ff       <= acc_in;
         out_mask_ff  <= out_mask_in;
         timer_ff     <= timer_in;
         threshold_ff <= threshold_in;
         delay_ff     <= delay_in;
      end
   end

   // result for a tick
   assign result_load       = item_go && is_tick;
   assign result.fired      = fire;
   assign result.spike_value = fire ? (acc_ff & out_mask_shift) : '0;

`ifndef NO_ASSERTIONS
   // a firing tick clears accumulator and output mask
   a_fire_clears: assert property (@(posedge clock) disable iff (reset)
      (item_go && is_tick && fire) |=> (acc_ff == '0 && out_mask_ff == '0))
      else $error("firing tick did not clear accumulator and output mask");

   // a firing tick reloads the refractory timer
   a_fire_loads_timer: assert property (@(posedge clock) disable iff (reset)
      (item_go && is_tick && fire) |=> (timer_ff == $past(delay_ff)))
      else $error("firing tick did not load the refractory timer");

   // an input event never lowers the accumulator
   a_event_no_drop: assert property (@(posedge clock) disable iff (reset)
      (item_go && !is_tick) |=> (acc_ff >= $past(acc_ff)))
      else $error("input event lowered the accumulator");

   // no firing while the timer is still running after its countdown
   a_refractory_hold: assert property (@(posedge clock) disable iff (reset)
      (timer_ff > 8'd1) |-> !fire)
      else $error("fire decision during refractory wait");
`endif

endmodule

// ===== hw/rtl/msn_output_reg.sv =====
// result register: holds one result until the receiver takes the transfer
`timescale 1ns / 1ps

module msn_output_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  msn_pkg::result_type         result,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_fired,
   output logic [msn_pkg::DATA_W-1:0]  rsp_spike_value
);

   logic                valid_ff;
   logic                valid_in;
   msn_pkg::result_type data_ff;
   msn_pkg::result_type data_in;

   // full and not being taken this cycle
   assign busy = valid_ff && rsp_stall;

   // next valid and payload
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_fired       = data_ff.fired;
   assign rsp_spike_value = data_ff.spike_value;

endmodule

// ===== hw/rtl/mask_synapse_spiking_neuron_core.sv =====
// top level of the mask synapse spiking neuron core
`timescale 1ns / 1ps

// Single spiking neuron with eight 8-bit mask synapses.
// Request channel (req_valid / req_stall): opcode 0 is a synapse input event that
// adds input_value AND the chosen synapse mask to the accumulator (saturating);
// opcode 1 is a time tick that decays the masks, runs the refractory timer and
// may fire. Only ticks produce a result; input events produce none.
// Result channel (rsp_valid / rsp_stall): fired and spike_value for each tick.
// Configuration channel (csr_valid / csr_ready): index 0 is the fire threshold,
// index 1 the refractory delay; other indexes are ignored. csr_ready is always
// high; write only while no item is in flight.
// A tick's result passes through the input register and then the result register;
// it is loaded at the edge that moves the tick out of the input register.
// Throughput: one item per cycle while nothing stalls; the state update sits
// between the input register and the result register.
// When the receiver stalls with a result pending, input events keep flowing;
// a tick waits in the input register and req_stall rises until the result
// register frees up.
// Reset (synchronous, active high) sets all masks to 0xFF, clears accumulator,
// output mask and timer, and loads both registers with 15.

module mask_synapse_spiking_neuron_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [0:0]                       req_opcode,
   input  logic [msn_pkg::SYN_IDX_W-1:0]    req_synapse_index,
   input  logic [msn_pkg::DATA_W-1:0]       req_input_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_fired,
   output logic [msn_pkg::DATA_W-1:0]       rsp_spike_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [msn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msn_pkg::DATA_W-1:0]       csr_data
);

   logic                item_valid;
   msn_pkg::item_type   item;
   logic                item_go;
   logic                out_busy;
   logic                result_load;
   msn_pkg::result_type result;

   // a tick may only move on when the result register can take it
   assign item_go   = item_valid && !(item.opcode == msn_pkg::OP_TICK && out_busy);
   assign csr_ready = 1'b1;

   msn_input_stage u_input_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_synapse_index (req_synapse_index),
      .req_input_value   (req_input_value),
      .advance           (item_go),
      .item_valid        (item_valid),
      .item              (item)
   );

   msn_neuron_core u_neuron_core (
      .clock       (clock),
      .reset       (reset),
      .item_go     (item_go),
      .item        (item),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .result_load (result_load),
      .result      (result)
   );

   msn_output_reg u_output_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (result_load),
      .result          (result),
      .busy            (out_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fired       (rsp_fired),
      .rsp_spike_value (rsp_spike_value)
   );

endmodule
